// ===== rtl/cfr_pkg.sv =====
`default_nettype none

package cfr_pkg;

   localparam int          MAX_DATA_DEFAULT = 32;
   localparam int          FRAME_OVERHEAD   = 5;
   localparam logic [7:0]  HDR_BYTE         = 8'h5A;

   typedef enum logic [1:0] {
      STATUS_GOOD    = 2'd0,
      STATUS_SUM_ERR = 2'd1,
      STATUS_LEN_ERR = 2'd2
   } status_type;

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic [7:0] frame_byte;
      logic [5:0] byte_index;
      logic       last;
      status_type status;
   } out_load_type;

endpackage

`default_nettype wire

// ===== rtl/cfr_req_if.sv =====
`default_nettype none

interface cfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfr_rsp_if.sv =====
`default_nettype none

interface cfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic [5:0] byte_index;
   logic       last;
   logic [1:0] status;

   modport source (output valid, output frame_byte, output byte_index, output last,
                   output status, input ready);
   modport sink   (input valid, input frame_byte, input byte_index, input last,
                   input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfr_frame_mem.sv =====
`default_nettype none

module cfr_frame_mem
   import cfr_pkg::*;
#(
   parameter  int DEPTH = MAX_DATA_DEFAULT + FRAME_OVERHEAD,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/cfr_control.sv =====
`default_nettype none

module cfr_control
   import cfr_pkg::*;
#(
   parameter  int MAX_DATA = MAX_DATA_DEFAULT,
   localparam int DEPTH    = MAX_DATA + FRAME_OVERHEAD,
   localparam int AW       = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [7:0]    req_rx_byte,
   output logic               req_ready,
   input  wire logic          out_free,
   output out_load_type       out_load,
   output logic               emitting,
   output logic               mem_wr_en,
   output logic [AW-1:0]      mem_wr_addr,
   output logic [7:0]         mem_wr_data,
   output logic               mem_rd_en,
   output logic [AW-1:0]      mem_rd_addr,
   input  wire logic [7:0]    mem_rd_data
);

   state_type  state_ff, state_in;
   logic [5:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [6:0] total_ff, total_in;
   logic [6:0] rd_ptr_ff, rd_ptr_in;
   logic       mem_valid_ff, mem_valid_in;
   logic [5:0] mem_idx_ff, mem_idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         sum_ff       <= '0;
         mem_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         mem_valid_ff <= mem_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff   <= total_in;
      rd_ptr_ff  <= rd_ptr_in;
      mem_idx_ff <= mem_idx_in;
   end

   always_comb begin
      logic accept;
      logic take;
      logic restart;
      logic issue;
      logic [7:0] b;

      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      total_in     = total_ff;
      rd_ptr_in    = rd_ptr_ff;
      mem_valid_in = mem_valid_ff;
      mem_idx_in   = mem_idx_ff;

      out_load            = '0;
      out_load.status     = STATUS_GOOD;
      mem_wr_en           = 1'b0;
      mem_wr_addr         = count_ff[AW-1:0];
      mem_wr_data         = req_rx_byte;
      mem_rd_en           = 1'b0;
      mem_rd_addr         = rd_ptr_ff[AW-1:0];

      take    = 1'b0;
      restart = 1'b0;
      issue   = 1'b0;
      b       = req_rx_byte;

      req_ready = (state_ff == ST_COLLECT) && out_free;
      emitting  = (state_ff == ST_EMIT);
      accept    = req_valid && req_ready;

      case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               case (count_ff)
                  6'd0: begin
                     take = (b == HDR_BYTE);
                  end
                  6'd1: begin
                     take    = (b == HDR_BYTE);
                     restart = (b != HDR_BYTE);
                  end
                  6'd2: begin
                     take = 1'b1;
                  end
                  6'd3: begin
                     if (b > 8'(MAX_DATA)) begin
                        restart         = 1'b1;
                        out_load.load   = 1'b1;
                        out_load.last   = 1'b1;
                        out_load.status = STATUS_LEN_ERR;
                     end else begin
                        take     = 1'b1;
                        total_in = 7'(b) + 7'(FRAME_OVERHEAD);
                     end
                  end
                  default: begin
                     if ({1'b0, count_ff} + 7'd1 < total_ff) begin
                        take = 1'b1;
                     end else begin
                        // checksum byte
                        mem_wr_en = 1'b1;
                        restart   = 1'b1;
                        if (b != sum_ff) begin
                           out_load.load   = 1'b1;
                           out_load.last   = 1'b1;
                           out_load.status = STATUS_SUM_ERR;
                        end else begin
                           state_in  = ST_EMIT;
                           rd_ptr_in = '0;
                        end
                     end
                  end
               endcase
            end
         end
         ST_EMIT: begin
            out_load.load       = mem_valid_ff && out_free;
            out_load.frame_byte = mem_rd_data;
            out_load.byte_index = mem_idx_ff;
            out_load.last       = ({1'b0, mem_idx_ff} + 7'd1 == total_ff);
            issue = (rd_ptr_ff < total_ff) && (!mem_valid_ff || out_load.load);
            if (issue) begin
               mem_rd_en    = 1'b1;
               rd_ptr_in    = rd_ptr_ff + 7'd1;
               mem_idx_in   = rd_ptr_ff[5:0];
               mem_valid_in = 1'b1;
            end else if (out_load.load) begin
               mem_valid_in = 1'b0;
            end
            if (out_load.load && out_load.last) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase

      if (take) begin
         mem_wr_en = 1'b1;
         sum_in    = sum_ff + b;
         count_in  = count_ff + 6'd1;
      end
      if (restart) begin
         count_in = '0;
         sum_in   = '0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/checksummed_frame_receiver.sv =====
`default_nettype none

// channel     port      direction  payload
// request     req_chan  in         rx_byte[7:0]
// response    rsp_chan  out        frame_byte[7:0] byte_index[5:0] last status[1:0]
//
// a byte that completes nothing is taken back to back while out_free is high
// a good frame of N bytes leaves after its checksum byte, one byte a cycle
// while rsp_chan.ready is high, paced by the frame memory read port
// no request is taken until the last frame byte sits in the output register
// reset clears state, count, sum and valid flags, never the frame memory
// rsp_chan.ready low holds the output register and the memory read pipeline

module checksummed_frame_receiver
   import cfr_pkg::*;
#(
   parameter int MAX_DATA = MAX_DATA_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   cfr_req_if.sink   req_chan,
   cfr_rsp_if.source rsp_chan
);

   localparam int DEPTH = MAX_DATA + FRAME_OVERHEAD;
   localparam int AW    = $clog2(DEPTH);

   out_load_type    out_load;
   logic            out_free;
   logic            emitting;
   logic            req_ready;

   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   logic [7:0]      mem_wr_data;
   logic            mem_rd_en;
   logic [AW-1:0]   mem_rd_addr;
   logic [7:0]      mem_rd_data;

   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff;
   logic [5:0]      out_index_ff;
   logic            out_last_ff;
   status_type      out_status_ff;

   assign out_free = !out_valid_ff || rsp_chan.ready;

   cfr_control #(
      .MAX_DATA (MAX_DATA)
   ) u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_rx_byte (req_chan.rx_byte),
      .req_ready   (req_ready),
      .out_free    (out_free),
      .out_load    (out_load),
      .emitting    (emitting),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   cfr_frame_mem #(
      .DEPTH (DEPTH)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load.load) begin
         out_byte_ff   <= out_load.frame_byte;
         out_index_ff  <= out_load.byte_index;
         out_last_ff   <= out_load.last;
         out_status_ff <= out_load.status;
      end
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.frame_byte = out_byte_ff;
   assign rsp_chan.byte_index = out_index_ff;
   assign rsp_chan.last       = out_last_ff;
   assign rsp_chan.status     = out_status_ff;

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      out_load.load |-> out_free)
      else $error("output register overwritten while a transaction waits");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (out_load.load && out_load.status != STATUS_GOOD) |->
         (out_load.last && out_load.frame_byte == 8'd0 && out_load.byte_index == 6'd0))
      else $error("error result with a non-zero payload");

   a_no_req_while_emitting: assert property (@(posedge clock) disable iff (reset)
      emitting |-> !req_ready)
      else $error("request taken during frame emission");

   a_first_byte_header: assert property (@(posedge clock) disable iff (reset)
      (out_load.load && out_load.status == STATUS_GOOD && out_load.byte_index == 6'd0)
         |-> (out_load.frame_byte == HDR_BYTE))
      else $error("emitted frame does not start with a header byte");

endmodule

`default_nettype wire
